/* rtl/bbt_pkg.sv */
// Shared constants and types for the Bollinger band tracker.
// Used by bollinger_band_tracker; no dependencies.
package bbt_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PRICE_BITS = 24;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int WIN_W      = 7;
  localparam int MULT_W     = 4;
  localparam int SUM_W      = PRICE_BITS + SLOT_W;
  localparam int SQ_W       = 2 * PRICE_BITS + SLOT_W;
  localparam int WIDE_W     = 64;
  localparam int FRAC_W     = 8;
  localparam int VFRAC_W    = 2 * FRAC_W;
  localparam int DQ_W       = WIDE_W + VFRAC_W;
  localparam int MID_DIV_W  = SUM_W + FRAC_W;
  localparam int DVS_W      = 2 * WIN_W - 1;
  localparam int DCNT_W     = $clog2(DQ_W + 1);
  localparam int MP_W       = 32;
  localparam int ROOT_W     = 32;
  localparam int MID_W      = 32;
  localparam int BAND_W     = 36;
  localparam int DEV_W      = MULT_W + ROOT_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd1;

  localparam logic [WIN_W-1:0]  WIN_MIN   = 7'd2;
  localparam logic [WIN_W-1:0]  WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0]  WIN_RST   = 7'd20;
  localparam logic [MULT_W-1:0] MULT_RST  = 4'd2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RD   = 12'b0000_0000_0010,
    S_PP   = 12'b0000_0000_0100,
    S_OO   = 12'b0000_0000_1000,
    S_MID  = 12'b0000_0001_0000,
    S_WSS  = 12'b0000_0010_0000,
    S_SS   = 12'b0000_0100_0000,
    S_WW   = 12'b0000_1000_0000,
    S_DIV  = 12'b0001_0000_0000,
    S_SQRT = 12'b0010_0000_0000,
    S_DEV  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

endpackage

/* rtl/bollinger_band_tracker.sv */
// Top level of the Bollinger band tracker: sample ring, running sums and a bit-serial datapath.
// Depends on bbt_pkg and bbt_ram.

// One price word is taken at a time and yields one result word. The work runs through a
// shift-add multiplier, a restoring divider and a square-root unit that each retire one bit
// per cycle; once the bands are valid, the 80-step variance divide and the 32-step square
// root dominate the work per item. A new price word is taken while the previous result
// still waits on the output. Writing the window length restarts the tracker; the ring
// needs no clearing after reset.
module bollinger_band_tracker
  import bbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // price[23:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [103:0]          out_tdata,  // middle_q8[31:0], upper_q8[67:32], lower_q8[103:68]
  output logic                  out_tuser,  // bands_valid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIN_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  logic [WIN_W-1:0]      wlen_r, wlen_nxt;
  logic [MULT_W-1:0]     mult_r, mult_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SQ_W-1:0]       sq_r, sq_nxt;
  logic [PRICE_BITS-1:0] p_r, p_nxt;
  logic [PRICE_BITS-1:0] old_r, old_nxt;
  logic [WIDE_W-1:0]     acc_r, acc_nxt;
  logic [WIDE_W-1:0]     mc_r, mc_nxt;
  logic [MP_W-1:0]       mp_r, mp_nxt;
  logic [DQ_W-1:0]       dq_r, dq_nxt;
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [WIDE_W-1:0]     d_r, d_nxt;
  logic [WIDE_W-1:0]     sv_r, sv_nxt;
  logic [WIDE_W-1:0]     res_r, res_nxt;
  logic [WIDE_W-1:0]     bit_r, bit_nxt;
  logic [MID_W-1:0]      mid_r, mid_nxt;
  logic [DEV_W-1:0]      dev_r, dev_nxt;
  logic                  bv_r, bv_nxt;
  logic                  ov_r, ov_nxt;
  logic [103:0]          od_r, od_nxt;
  logic                  ou_r, ou_nxt;

  logic [SLOT_W-1:0]     raddr;
  logic [PRICE_BITS-1:0] rdata;
  logic                  ram_we;
  logic [DVS_W:0]        rs;
  logic [WIDE_W-1:0]     sq_t;
  logic [CNT_W-1:0]      cnt_up;
  logic [WIN_W-1:0]      nsel;
  logic [WIN_W-1:0]      wclamp;
  logic [BAND_W-1:0]     upper, lower;
  logic                  out_free;

  assign raddr     = slot_r - wlen_r[SLOT_W-1:0];
  assign ram_we    = (state_r == S_RD);
  assign in_tready = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_free   = !ov_r || out_tready;

  bbt_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (p_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rs     = {rem_r, dq_r[DQ_W-1]};
    sq_t   = res_r + bit_r;
    cnt_up = (CNT_W'(cnt_r) < CNT_W'(wlen_r) + CNT_W'(1)) ? cnt_r + CNT_W'(1) : cnt_r;
    nsel   = (cnt_r < CNT_W'(wlen_r)) ? WIN_W'(cnt_r) : wlen_r;
    wclamp = (cfg_data < WIN_MIN) ? WIN_MIN : ((cfg_data > WIN_MAX) ? WIN_MAX : cfg_data);
    upper  = BAND_W'(mid_r) + BAND_W'(dev_r);
    lower  = BAND_W'(mid_r) - BAND_W'(dev_r);
  end

  always_comb begin
    state_nxt = state_r;
    wlen_nxt = wlen_r;  mult_nxt = mult_r;  slot_nxt = slot_r;  cnt_nxt = cnt_r;
    sum_nxt = sum_r;    sq_nxt = sq_r;      p_nxt = p_r;        old_nxt = old_r;
    acc_nxt = acc_r;    mc_nxt = mc_r;      mp_nxt = mp_r;      dq_nxt = dq_r;
    rem_nxt = rem_r;    dvs_nxt = dvs_r;    dcnt_nxt = dcnt_r;  d_nxt = d_r;
    sv_nxt = sv_r;      res_nxt = res_r;    bit_nxt = bit_r;    mid_nxt = mid_r;
    dev_nxt = dev_r;    bv_nxt = bv_r;      ov_nxt = ov_r;      od_nxt = od_r;
    ou_nxt = ou_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          unique case (cfg_index)
            REG_WINDOW: begin
              wlen_nxt = wclamp;
              slot_nxt = '0;
              cnt_nxt  = '0;
              sum_nxt  = '0;
              sq_nxt   = '0;
            end
            REG_MULT: mult_nxt = cfg_data[MULT_W-1:0];
            default: ;
          endcase
        end else if (in_tvalid) begin
          p_nxt     = in_tdata;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        old_nxt   = (cnt_r >= CNT_W'(wlen_r)) ? rdata : '0;
        sum_nxt   = sum_r - SUM_W'(old_nxt) + SUM_W'(p_r);
        slot_nxt  = slot_r + SLOT_W'(1);
        cnt_nxt   = cnt_up;
        acc_nxt   = '0;
        mc_nxt    = WIDE_W'(p_r);
        mp_nxt    = MP_W'(p_r);
        state_nxt = S_PP;
      end
      S_PP, S_OO, S_WSS, S_SS, S_WW: begin
        if (mp_r != '0) begin
          if (mp_r[0]) begin
            acc_nxt = acc_r + mc_r;
          end
          mc_nxt = {mc_r[WIDE_W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[MP_W-1:1]};
        end else begin
          acc_nxt = '0;
          unique case (state_r)
            S_PP: begin
              sq_nxt    = sq_r + SQ_W'(acc_r);
              mc_nxt    = WIDE_W'(old_r);
              mp_nxt    = MP_W'(old_r);
              state_nxt = S_OO;
            end
            S_OO: begin
              sq_nxt    = sq_r - SQ_W'(acc_r);
              dq_nxt    = {sum_r, {FRAC_W{1'b0}}, {(DQ_W - MID_DIV_W){1'b0}}};
              rem_nxt   = '0;
              dvs_nxt   = DVS_W'(nsel);
              dcnt_nxt  = DCNT_W'(MID_DIV_W);
              state_nxt = S_MID;
            end
            S_WSS: begin
              d_nxt     = acc_r;
              mc_nxt    = WIDE_W'(sum_r);
              mp_nxt    = MP_W'(sum_r);
              state_nxt = S_SS;
            end
            S_SS: begin
              d_nxt     = d_r - acc_r;
              mc_nxt    = WIDE_W'(wlen_r);
              mp_nxt    = MP_W'(wlen_r);
              state_nxt = S_WW;
            end
            default: begin
              dvs_nxt   = acc_r[DVS_W-1:0];
              dq_nxt    = {d_r, {VFRAC_W{1'b0}}};
              rem_nxt   = '0;
              dcnt_nxt  = DCNT_W'(DQ_W);
              state_nxt = S_DIV;
            end
          endcase
        end
      end
      S_MID, S_DIV: begin
        if (dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - DCNT_W'(1);
          if (rs >= {1'b0, dvs_r}) begin
            rem_nxt = DVS_W'(rs - {1'b0, dvs_r});
            dq_nxt  = {dq_r[DQ_W-2:0], 1'b1};
          end else begin
            rem_nxt = rs[DVS_W-1:0];
            dq_nxt  = {dq_r[DQ_W-2:0], 1'b0};
          end
        end else if (state_r == S_MID) begin
          mid_nxt = dq_r[MID_W-1:0];
          bv_nxt  = (cnt_r > CNT_W'(wlen_r));
          dev_nxt = '0;
          if (bv_nxt) begin
            acc_nxt   = '0;
            mc_nxt    = WIDE_W'(sq_r);
            mp_nxt    = MP_W'(wlen_r);
            state_nxt = S_WSS;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          sv_nxt    = dq_r[WIDE_W-1:0];
          res_nxt   = '0;
          bit_nxt   = WIDE_W'(1) << (WIDE_W - 2);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (bit_r != '0) begin
          if (sv_r >= sq_t) begin
            sv_nxt  = sv_r - sq_t;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else begin
          state_nxt = S_DEV;
        end
      end
      S_DEV: begin
        dev_nxt   = DEV_W'(mult_r) * DEV_W'(res_r[ROOT_W-1:0]);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ou_nxt    = bv_r;
          od_nxt    = bv_r ? {lower, upper, mid_r} : {{(2 * BAND_W){1'b0}}, mid_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlen_r  <= WIN_RST;
      mult_r  <= MULT_RST;
      slot_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      mult_r  <= mult_nxt;
      slot_r  <= slot_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;    old_r  <= old_nxt;  acc_r  <= acc_nxt;  mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;   dq_r   <= dq_nxt;   rem_r  <= rem_nxt;  dvs_r  <= dvs_nxt;
    dcnt_r <= dcnt_nxt; d_r    <= d_nxt;    sv_r   <= sv_nxt;   res_r  <= res_nxt;
    bit_r  <= bit_nxt;  mid_r  <= mid_nxt;  dev_r  <= dev_nxt;  bv_r   <= bv_nxt;
    od_r   <= od_nxt;   ou_r   <= ou_nxt;
  end

endmodule

/* rtl/bbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
